### hdl/fclp_pkg.sv
// Shared constants and tap arithmetic for the four-channel FIR low-pass filter.
package fclp_pkg;

  // Filter geometry
  localparam int TAPS         = 10;
  localparam int CHANNELS_DEF = 4;

  // Field widths
  localparam int CH_W   = 2;
  localparam int SMP_W  = 16;
  localparam int ACC_W  = 32;
  localparam int COEF_W = 17;

  typedef logic [SMP_W-1:0] sample_t;
  typedef logic [ACC_W-1:0] acc_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  // Q16 low-pass coefficients, tap 0 (newest) first
  localparam coef_t COEF [TAPS] = '{
    -17'sd2605, -17'sd4732, 17'sd3500, 17'sd20841, 17'sd30419,
    17'sd20841, 17'sd3500, -17'sd4732, -17'sd2605, 17'sd1108
  };

  // One weighted tap, reduced modulo 2^32 (two's complement wrap)
  function automatic acc_t tap_term(input sample_t tap, input coef_t coef);
    logic signed [2*COEF_W-1:0] prod;
    logic signed [COEF_W-1:0]   tap_s;
    tap_s = $signed({1'b0, tap});
    prod  = coef * tap_s;
    return prod[ACC_W-1:0];
  endfunction

endpackage

### hdl/four_channel_fir_lowpass_top.sv
// Four-channel 10-tap FIR low-pass filter with per-channel delay lines.
//
//  channel | direction | tdata               | tuser         | tlast
//  in_     | slave     | [15:0] sample       | [1:0] channel | -
//  out_    | master    | [15:0] filtered     | [1:0] channel | -
//
// One request per cycle sustained while out_tready stays high; an accepted
// request passes an input register holding the shifted tap snapshot, then the
// constant-coefficient multiply and adder tree into the result register that drives out_tvalid.
// rst_n (synchronous) loads tap 0 of each channel with channel + 1, others zero.
// A stall on out_tready holds the result register and backs up into the input
// register; in_tready drops only when both stages are full.
module four_channel_fir_lowpass_top #(
  parameter int CHANNELS = fclp_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic [1:0]  in_tuser,   // [1:0] channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] filtered
  output logic [1:0]  out_tuser   // [1:0] out_channel
);

  localparam int TAPS = fclp_pkg::TAPS;

  // Delay lines, one row per channel
  fclp_pkg::sample_t line_r [CHANNELS][TAPS];

  // Input stage
  logic              s1_vld_r;
  logic              s1_hit_r;
  logic [1:0]        s1_ch_r;
  fclp_pkg::sample_t s1_tap_r [TAPS];

  // Result stage
  logic              out_vld_r;
  logic [1:0]        out_ch_r;
  logic [15:0]       out_dat_r;

  logic              in_acc;
  logic              s1_adv;
  logic              out_adv;
  logic              hit;
  logic [CHANNELS-1:0] ch_sel;
  fclp_pkg::sample_t old_tap [TAPS];
  fclp_pkg::acc_t    acc;
  logic [15:0]       filt_nxt;

  // Handshake: each stage advances when its downstream slot is free
  assign out_adv   = !out_vld_r || out_tready;
  assign s1_adv    = !s1_vld_r || out_adv;
  assign in_tready = s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Channel decode and selection of the addressed row
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      ch_sel[c] = (int'(in_tuser) == c);
    end
    hit = |ch_sel;
    for (int k = 0; k < TAPS; k++) begin
      old_tap[k] = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        old_tap[k] = old_tap[k] | (line_r[c][k] & {fclp_pkg::SMP_W{ch_sel[c]}});
      end
    end
  end

  // Delay line shift on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < TAPS; k++) begin
          line_r[c][k] <= (k == 0) ? fclp_pkg::SMP_W'(c + 1) : '0;
        end
      end
    end else if (in_acc) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (ch_sel[c]) begin
          line_r[c][0] <= in_tdata;
          for (int k = 1; k < TAPS; k++) begin
            line_r[c][k] <= line_r[c][k-1];
          end
        end
      end
    end
  end

  // Input register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_adv) begin
      s1_vld_r <= in_tvalid;
    end
  end

  // Input register: snapshot of the shifted line
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_hit_r    <= hit;
      s1_ch_r     <= in_tuser;
      s1_tap_r[0] <= in_tdata;
      for (int k = 1; k < TAPS; k++) begin
        s1_tap_r[k] <= old_tap[k-1];
      end
    end
  end

  // Weighted sum, wrapped to 32 bits
  always_comb begin
    acc = '0;
    for (int k = 0; k < TAPS; k++) begin
      acc = acc + fclp_pkg::tap_term(s1_tap_r[k], fclp_pkg::COEF[k]);
    end
    filt_nxt = s1_hit_r ? acc[31:16] : '0;
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (out_adv && s1_vld_r) begin
      out_ch_r  <= s1_ch_r;
      out_dat_r <= filt_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;
  assign out_tuser  = out_ch_r;

endmodule
